### hw/rtl/tllbp_pkg.sv
`default_nettype none
package tllbp_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);
  localparam int CTR_W = 8;
  localparam int ADDR_W = 32;
  localparam int PADDR_W = 4;

  localparam logic [CTR_W-1:0] THRESHOLD_RESET = 8'd1;
  localparam logic [CTR_W-1:0] FLOOR_RESET = 8'd0;
  localparam logic [CTR_W-1:0] CEILING_RESET = 8'd3;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_FLOOR     = 2'd1,
    REG_CEILING   = 2'd2,
    REG_SPARE     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_CTR
  } state_t;

  typedef struct packed {
    logic [CTR_W-1:0] threshold;
    logic [CTR_W-1:0] floor;
    logic [CTR_W-1:0] ceiling;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } hist_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [CTR_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ctr_req_t;

endpackage
`default_nettype wire

### hw/rtl/two_level_local_branch_predictor_core.sv
`default_nettype none
// Two-level local branch predictor. An item is taken when start is high and busy
// is low; it is a predict request (kind 0) or a train request (kind 1). Each item
// passes through the accept cycle (ST_IDLE), the history table read (ST_HIST)
// and the pattern counter read (ST_CTR), which depends on that history; a train
// request writes both tables back at the end of ST_CTR. A predict request gives
// predict_taken with result_valid high for one cycle, registered from ST_CTR;
// the receiver cannot stall it, and the next item may be accepted in the cycle
// that result_valid is high. A train request gives no result. After reset a
// clearing pass over all TABLE_ENTRIES (1024) entries initialises both tables,
// with busy held high; register writes on the APB port are taken at any time.
module two_level_local_branch_predictor_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind,
  input  wire logic [tllbp_pkg::ADDR_W-1:0]  branch_address,
  input  wire logic                          taken,
  output logic                               result_valid,
  output logic                               predict_taken,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tllbp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import tllbp_pkg::*;

  cfg_t             cfg;
  hist_req_t        hist_req;
  ctr_req_t         ctr_req;
  logic [IDX_W-1:0] hist_rdata;
  logic [CTR_W-1:0] ctr_rdata;
  reg_idx_t         reg_sel;

  assign pready = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RESET;
      cfg.floor <= FLOOR_RESET;
      cfg.ceiling <= CEILING_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_THRESHOLD: cfg.threshold <= pwdata[CTR_W-1:0];
        REG_FLOOR:     cfg.floor <= pwdata[CTR_W-1:0];
        REG_CEILING:   cfg.ceiling <= pwdata[CTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: prdata = {{(32-CTR_W){1'b0}}, cfg.threshold};
      REG_FLOOR:     prdata = {{(32-CTR_W){1'b0}}, cfg.floor};
      REG_CEILING:   prdata = {{(32-CTR_W){1'b0}}, cfg.ceiling};
      default:       prdata = '0;
    endcase
  end

  tllbp_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .branch_address (branch_address),
    .taken          (taken),
    .result_valid   (result_valid),
    .predict_taken  (predict_taken),
    .cfg            (cfg),
    .hist_req       (hist_req),
    .hist_rdata     (hist_rdata),
    .ctr_req        (ctr_req),
    .ctr_rdata      (ctr_rdata)
  );

  tllbp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_req.we),
    .waddr (hist_req.waddr),
    .wdata (hist_req.wdata),
    .raddr (hist_req.raddr),
    .rdata (hist_rdata)
  );

  tllbp_ram #(
    .WIDTH (CTR_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_req.we),
    .waddr (ctr_req.waddr),
    .wdata (ctr_req.wdata),
    .raddr (ctr_req.raddr),
    .rdata (ctr_rdata)
  );

endmodule
`default_nettype wire

### hw/rtl/tllbp_ram.sv
`default_nettype none
module tllbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/tllbp_ctrl.sv
`default_nettype none
module tllbp_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           kind,
  input  wire logic [tllbp_pkg::ADDR_W-1:0]   branch_address,
  input  wire logic                           taken,
  output logic                                result_valid,
  output logic                                predict_taken,
  input  wire tllbp_pkg::cfg_t                cfg,
  output tllbp_pkg::hist_req_t                hist_req,
  input  wire logic [tllbp_pkg::IDX_W-1:0]    hist_rdata,
  output tllbp_pkg::ctr_req_t                 ctr_req,
  input  wire logic [tllbp_pkg::CTR_W-1:0]    ctr_rdata
);
  import tllbp_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] hist;
  logic             kind_q;
  logic             taken_q;
  logic [CTR_W-1:0] ctr_new;
  logic             accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      result_valid <= (state == ST_CTR) && !kind_q;
    end
  end

  // Payload capture: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      slot <= branch_address[IDX_W-1:0] & IDX_MASK;
      kind_q <= kind;
      taken_q <= taken;
    end
    if (state == ST_HIST) begin
      hist <= hist_rdata & IDX_MASK;
    end
    if (state == ST_CTR) begin
      predict_taken <= ctr_rdata > cfg.threshold;
    end
  end

  // Saturating move, each bound tested on its own
  always_comb begin
    ctr_new = ctr_rdata;
    if (taken_q) begin
      if (ctr_rdata < cfg.ceiling) begin
        ctr_new = ctr_rdata + 1'b1;
      end
    end else if (ctr_rdata > cfg.floor) begin
      ctr_new = ctr_rdata - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    busy = 1'b1;
    hist_req.raddr = branch_address[IDX_W-1:0] & IDX_MASK;
    hist_req.we = 1'b0;
    hist_req.waddr = slot;
    hist_req.wdata = ((hist << 1) | IDX_W'(taken_q)) & IDX_MASK;
    ctr_req.raddr = hist_rdata & IDX_MASK;
    ctr_req.we = 1'b0;
    ctr_req.waddr = hist;
    ctr_req.wdata = ctr_new;
    case (state)
      ST_CLEAR: begin
        hist_req.we = 1'b1;
        hist_req.waddr = clr_idx;
        hist_req.wdata = '0;
        ctr_req.we = 1'b1;
        ctr_req.waddr = clr_idx;
        ctr_req.wdata = CEILING_RESET;
        if (clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_HIST;
        end
      end
      ST_HIST: begin
        state_next = ST_CTR;
      end
      ST_CTR: begin
        // write back so the next item's history read sees it
        hist_req.we = kind_q;
        ctr_req.we = kind_q;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/tllbp_checker.sv
`default_nettype none
module tllbp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic kind,
  input wire logic result_valid
);

  // clearing pass follows every reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low straight after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 (result_valid == !$past(kind, 3)))
    else $error("result strobe does not match accepted request kind");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

endmodule

bind two_level_local_branch_predictor_core tllbp_checker u_tllbp_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .kind         (kind),
  .result_valid (result_valid)
);
`default_nettype wire
